[hw/rtl/swhc_pkg.sv]
// Shared constants and the bucket entry type of the sliding window hit counter.
package swhc_pkg;

	localparam int STAMP_W = 32;
	localparam int CNT_W   = 16;
	localparam int TOTAL_W = 25;

	localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [STAMP_W-1:0] second;
		logic [CNT_W-1:0]   count;
	} bucket_t;

endpackage

[hw/rtl/swhc_mod_unit.sv]
// Remainder of a stamp by the window length through reciprocal multiplication.
module swhc_mod_unit #(
	parameter int WINDOW_SECONDS = 300
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [swhc_pkg::STAMP_W-1:0]        dividend,
	output logic                                done,
	output logic [$clog2(WINDOW_SECONDS)-1:0]   rem
);
	import swhc_pkg::*;

	localparam int AW = $clog2(WINDOW_SECONDS);
	localparam int MW = STAMP_W + 1;
	localparam int PW = STAMP_W + MW;
	localparam int QW = MW - AW;
	localparam longint unsigned RECIP =
		((64'd1 << (STAMP_W + AW)) + 64'(WINDOW_SECONDS) - 64'd1) / 64'(WINDOW_SECONDS);

	logic [STAMP_W-1:0] dvd_q;
	logic               load_q;
	logic [QW-1:0]      quo_s1;
	logic               valid_s1;
	logic [AW-1:0]      rem_s2;
	logic               valid_s2;
	logic [PW-1:0]      prod;
	logic [STAMP_W-1:0] back;
	logic [STAMP_W-1:0] diff;

	assign prod = PW'(dvd_q) * PW'(RECIP);
	assign back = STAMP_W'(quo_s1) * STAMP_W'(WINDOW_SECONDS);
	assign diff = dvd_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			load_q   <= start;
			valid_s1 <= load_q;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
		end
		quo_s1 <= prod[PW-1 -: QW];
		rem_s2 <= diff[AW-1:0];
	end

	assign done = valid_s2;
	assign rem  = rem_s2;

endmodule

[hw/rtl/swhc_bucket_mem.sv]
// Bucket store: one write port, one read port with registered read data.
module swhc_bucket_mem #(
	parameter int DEPTH = 300
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output swhc_pkg::bucket_t           rd_data,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  swhc_pkg::bucket_t           wr_data
);
	import swhc_pkg::*;

	bucket_t mem_q [DEPTH];
	bucket_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/sliding_window_hit_counter.sv]
// Sliding window hit counter: top level with sequencer, scan pipeline and output register.
// Sequence: an item without a hit goes from accept straight to the scan of every bucket.
// An item with a hit goes first through the reciprocal remainder, then a
// read-modify-write of the bucket, then the scan of every bucket, one memory read per cycle.
// Throughput: one item at a time; inputs stay stalled until the result reaches the output
// register, which out_stall can hold off; the bucket store's single read port sets the rate.
// Reset: a clearing pass writes every bucket to zero, inputs stalled.
module sliding_window_hit_counter #(
	parameter int WINDOW_SECONDS = 300
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [swhc_pkg::STAMP_W-1:0]    stamp,
	input  logic                            record_hit,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [swhc_pkg::TOTAL_W-1:0]    window_total
);
	import swhc_pkg::*;

	localparam int AW = $clog2(WINDOW_SECONDS);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_MOD    = 8'b0000_0100,
		ST_UPD_RD = 8'b0000_1000,
		ST_UPD_WR = 8'b0001_0000,
		ST_SCAN   = 8'b0010_0000,
		ST_DRAIN  = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      idx_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [TOTAL_W-1:0] acc_q;
	logic               out_valid_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               valid_s1;
	logic               valid_s2;
	logic [CNT_W-1:0]   cnt_s2;

	logic               in_accept;
	logic               idx_last;
	logic               mod_start;
	logic               mod_done;
	logic [AW-1:0]      mod_rem;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	bucket_t            rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	bucket_t            wr_data;
	bucket_t            upd;
	logic [STAMP_W-1:0] age;
	logic               in_window;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] acc_nx;
	logic               out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign idx_last  = (idx_q == AW'(WINDOW_SECONDS - 1));
	assign mod_start = in_accept && record_hit;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	swhc_mod_unit #(
		.WINDOW_SECONDS(WINDOW_SECONDS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (stamp),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	swhc_bucket_mem #(
		.DEPTH(WINDOW_SECONDS)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_comb begin
		upd = rd_data;
		if (rd_data.second != stamp_q) begin
			upd.second = stamp_q;
			upd.count  = CNT_W'(1);
		end else if (rd_data.count != COUNT_MAX) begin
			upd.count = rd_data.count + 1'b1;
		end
	end

	assign rd_en   = (state_q == ST_UPD_RD) || (state_q == ST_SCAN);
	assign rd_addr = (state_q == ST_SCAN) ? idx_q : mod_rem;
	assign wr_en   = (state_q == ST_CLEAR) || (state_q == ST_UPD_WR);
	assign wr_addr = (state_q == ST_CLEAR) ? idx_q : mod_rem;
	assign wr_data = (state_q == ST_CLEAR) ? bucket_t'('0) : upd;

	assign age       = stamp_q - rd_data.second;
	assign in_window = (rd_data.second <= stamp_q) && (age < STAMP_W'(WINDOW_SECONDS));

	assign sum    = {1'b0, acc_q} + (TOTAL_W + 1)'(cnt_s2);
	assign acc_nx = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			valid_s2 <= valid_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= record_hit ? ST_MOD : ST_SCAN;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_UPD_RD;
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_WR;
				end
				ST_UPD_WR: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					idx_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			stamp_q <= stamp;
			acc_q   <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_nx;
		end
		cnt_s2 <= in_window ? rd_data.count : '0;
		if (out_load) begin
			out_total_q <= acc_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign window_total = out_total_q;

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD_RD |-> 32'(mod_rem) < WINDOW_SECONDS)
		else $error("bucket slot beyond window");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("scan pipeline stage out of order");

	a_hit_starts_mod: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && record_hit |=> state_q == ST_MOD && !mod_done)
		else $error("hit item did not start remainder");

endmodule
